@@ rtl/cba_pkg.sv @@
// Package for the contiguous block allocator: widths, codes, controller states
// and the per-word search result type. No dependencies.
package cba_pkg;

  localparam int WORD_BITS  = 16;
  localparam int POS_W      = 4;
  localparam int TAIL_W     = 5;
  localparam int LEN_W      = 11;
  localparam int START_W    = 10;
  localparam int CARRY_W    = 11;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [START_W-1:0] FUB_RESET = 10'd100;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_FREE    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [POS_W-1:0]  pos;
    logic              all_free;
    logic [TAIL_W-1:0] tail;
  } eval_t;

endpackage

@@ rtl/cba_bitmap_ram.sv @@
// Bitmap memory of the allocator: one word of use marks per entry, one write
// and one registered read port. Depends on cba_pkg.
module cba_bitmap_ram import cba_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output word_t         rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cba_word_eval.sv @@
// Search logic for one bitmap word: finds the first block where a free run
// of the requested length ends, and the free run left at the top of the word.
// Depends on cba_pkg.
module cba_word_eval import cba_pkg::*; (
  input  word_t              used,
  input  logic [CARRY_W-1:0] carry,
  input  logic [LEN_W-1:0]   len,
  output eval_t              res
);

  always_comb begin
    logic [WORD_BITS-1:0] hitv;
    logic                 win_free;
    logic                 pre_free;
    logic [LEN_W:0]       reach;
    word_t                topmask;
    hitv = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      win_free = 1'b1;
      pre_free = 1'b1;
      for (int b = 0; b < WORD_BITS; b++) begin
        if (b <= j) begin
          pre_free = pre_free & ~used[b];
          if (LEN_W'(j - b) < len) begin
            win_free = win_free & ~used[b];
          end
        end
      end
      reach = (LEN_W+1)'(carry) + (LEN_W+1)'(j) + 1'b1;
      hitv[j] = (len != '0) &&
                (((LEN_W'(j) + 1'b1 >= len) && win_free) ||
                 (pre_free && (reach >= {1'b0, len})));
    end
    res.hit = |hitv;
    res.pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hitv[j]) begin
        res.pos = POS_W'(j);
      end
    end
    res.all_free = ~|used;
    res.tail = '0;
    for (int t = 1; t <= WORD_BITS; t++) begin
      topmask = {WORD_BITS{1'b1}} << (WORD_BITS - t);
      if ((used & topmask) == '0) begin
        res.tail = TAIL_W'(t);
      end
    end
  end

endmodule

@@ rtl/cba_run_mask.sv @@
// Bit mask of the blocks of one bitmap word that fall inside a run given by
// its first and last word and bit. Depends on cba_pkg.
module cba_run_mask import cba_pkg::*; #(
  parameter int AW = 6
) (
  input  logic [AW-1:0]    addr,
  input  logic [AW-1:0]    s_addr,
  input  logic [POS_W-1:0] s_bit,
  input  logic [AW-1:0]    e_addr,
  input  logic [POS_W-1:0] e_bit,
  output word_t            mask
);

  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] hi;

  always_comb begin
    lo = (addr == s_addr) ? s_bit : '0;
    hi = (addr == e_addr) ? e_bit : '1;
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (POS_W'(b) >= lo) && (POS_W'(b) <= hi);
    end
  end

endmodule

@@ rtl/contiguous_block_allocator_unit.sv @@
// Top level of the first-fit contiguous block allocator: controller, scan and
// marking datapath. Depends on cba_pkg, cba_bitmap_ram, cba_word_eval and
// cba_run_mask.
//
// Requests arrive on the s_axis channel, one result word per request leaves
// on m_axis. An allocate request scans the bitmap one 16-block word per cycle
// from the word holding first_usable_block, then rewrites the words of the
// found run one per cycle, as the one-word memory port allows. A full scan
// at 1024 blocks is 64 word reads. A free request rewrites the words of its
// run without a scan, and a zero-length allocate goes straight to its
// result. s_axis_tready is high only while idle, so a request is taken only
// once the result of the one before has gone into the output register.
// After reset the block clears the bitmap, one word per cycle, all
// ceil(NUM_BLOCKS/16) words (64 at 1024 blocks), with s_axis_tready low;
// first_usable_block resets to 100 and can be written through cfg_we; the
// user should write it only while the block is idle, as the block does not
// enforce this. The result sits in an output register: when the receiver
// stalls, one more request is taken and worked on, and its result waits until
// the output register is free.
module contiguous_block_allocator_unit import cba_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [START_W-1:0]     cfg_wdata,     // first_usable_block
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // run_start [9:0], run_length [20:10]
  input  logic                   s_axis_tuser,  // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // granted_start [9:0]
  output logic                   m_axis_tuser   // status
);

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (BW > POS_W) ? BW - POS_W : 1;
  localparam int EW = ((BW > LEN_W) ? BW : LEN_W) + 2;
  localparam logic [EW-1:0] N_EXT = EW'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [AW:0] WORDS_EXT = (AW+1)'(WORDS);

  state_t state, state_next;

  logic [START_W-1:0] fub;
  logic [LEN_W-1:0]   len;
  logic               mark_val;
  logic [AW:0]        rd_ptr;
  logic [AW-1:0]      eval_addr;
  logic               eval_valid;
  logic [CARRY_W-1:0] carry;
  logic [AW-1:0]      s_addr, e_addr;
  logic [POS_W-1:0]   s_bit, e_bit;
  logic [AW:0]        mk_ptr;
  logic               wb_valid;
  logic [AW-1:0]      wb_addr;
  logic [AW-1:0]      clr_addr;
  logic               res_status;
  logic [START_W-1:0] res_start;
  logic               out_valid;
  logic               out_status;
  logic [START_W-1:0] out_start;

  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  word_t         rdata, wdata;
  word_t         used_w;
  word_t         mask;
  eval_t         ev;

  logic               in_acc;
  logic [START_W-1:0] in_start;
  logic [LEN_W-1:0]   in_len;
  logic [EW-1:0]      fs_ext, fe_full, fe_clip;
  logic               free_noop, alloc_noop;
  logic [AW-1:0]      fub_word;
  logic [EW-1:0]      hit_end, hit_start;
  logic [CARRY_W:0]   carry_sum;
  logic [CARRY_W-1:0] carry_upd;
  logic               scan_issue, scan_fail, mark_issue, mark_last, done_load;

  cba_bitmap_ram #(.DEPTH(WORDS), .AW(AW)) u_ram (
    .clk   (clk),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  cba_word_eval u_eval (
    .used  (used_w),
    .carry (carry),
    .len   (len),
    .res   (ev)
  );

  cba_run_mask #(.AW(AW)) u_mask (
    .addr   (wb_addr),
    .s_addr (s_addr),
    .s_bit  (s_bit),
    .e_addr (e_addr),
    .e_bit  (e_bit),
    .mask   (mask)
  );

  assign in_start = s_axis_tdata[START_W-1:0];
  assign in_len = s_axis_tdata[START_W+LEN_W-1:START_W];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    fs_ext = EW'(in_start);
    fe_full = fs_ext + EW'(in_len) - 1'b1;
    fe_clip = (fe_full >= N_EXT) ? N_EXT - 1'b1 : fe_full;
    free_noop = (in_len == '0) || (fs_ext >= N_EXT);
    alloc_noop = (in_len == '0) || (EW'(fub) >= N_EXT);
    fub_word = AW'(fub >> POS_W);
    for (int b = 0; b < WORD_BITS; b++) begin
      used_w[b] = rdata[b] ||
                  (((EW'(eval_addr) << POS_W) | EW'(b)) < EW'(fub)) ||
                  (((EW'(eval_addr) << POS_W) | EW'(b)) >= N_EXT);
    end
    hit_end = (EW'(eval_addr) << POS_W) | EW'(ev.pos);
    hit_start = hit_end - EW'(len) + 1'b1;
    carry_sum = (CARRY_W+1)'(carry) + (CARRY_W+1)'(WORD_BITS);
    if (ev.all_free) begin
      carry_upd = carry_sum[CARRY_W] ? '1 : carry_sum[CARRY_W-1:0];
    end else begin
      carry_upd = CARRY_W'(ev.tail);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    scan_issue = (state == ST_SCAN) && (rd_ptr < WORDS_EXT) && !(eval_valid && ev.hit);
    scan_fail = (state == ST_SCAN) && eval_valid && !ev.hit && (eval_addr == LAST_WORD);
    mark_issue = (state == ST_MARK) && (mk_ptr <= {1'b0, e_addr});
    mark_last = (state == ST_MARK) && wb_valid && (wb_addr == e_addr);
    done_load = (state == ST_DONE) && (!out_valid || m_axis_tready);
    s_axis_tready = (state == ST_IDLE);
    re = scan_issue || mark_issue;
    raddr = (state == ST_MARK) ? mk_ptr[AW-1:0] : rd_ptr[AW-1:0];
    we = (state == ST_CLEAR) || ((state == ST_MARK) && wb_valid);
    waddr = (state == ST_CLEAR) ? clr_addr : wb_addr;
    if (state == ST_CLEAR) begin
      wdata = '0;
    end else begin
      wdata = mark_val ? (rdata | mask) : (rdata & ~mask);
    end
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == REQ_FREE) begin
            state_next = free_noop ? ST_DONE : ST_MARK;
          end else begin
            state_next = alloc_noop ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (eval_valid && ev.hit) begin
          state_next = ST_MARK;
        end else if (scan_fail) begin
          state_next = ST_DONE;
        end
      end
      ST_MARK: begin
        if (mark_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fub <= FUB_RESET;
      clr_addr <= '0;
      eval_valid <= 1'b0;
      wb_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        fub <= cfg_wdata;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      eval_valid <= scan_issue;
      eval_addr <= rd_ptr[AW-1:0];
      wb_valid <= mark_issue;
      wb_addr <= mk_ptr[AW-1:0];
      if (scan_issue) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (mark_issue) begin
        mk_ptr <= mk_ptr + 1'b1;
      end
      if (in_acc) begin
        len <= in_len;
        res_start <= '0;
        carry <= '0;
        rd_ptr <= {1'b0, fub_word};
        if (s_axis_tuser == REQ_FREE) begin
          res_status <= STATUS_OK;
          mark_val <= 1'b0;
          s_addr <= AW'(fs_ext >> POS_W);
          s_bit <= fs_ext[POS_W-1:0];
          e_addr <= AW'(fe_clip >> POS_W);
          e_bit <= fe_clip[POS_W-1:0];
          mk_ptr <= {1'b0, AW'(fs_ext >> POS_W)};
        end else begin
          res_status <= alloc_noop ? STATUS_FAIL : STATUS_OK;
        end
      end
      if ((state == ST_SCAN) && eval_valid) begin
        if (ev.hit) begin
          res_status <= STATUS_OK;
          res_start <= START_W'(hit_start);
          mark_val <= 1'b1;
          s_addr <= AW'(hit_start >> POS_W);
          s_bit <= hit_start[POS_W-1:0];
          e_addr <= AW'(hit_end >> POS_W);
          e_bit <= hit_end[POS_W-1:0];
          mk_ptr <= {1'b0, AW'(hit_start >> POS_W)};
        end else begin
          carry <= carry_upd;
          if (scan_fail) begin
            res_status <= STATUS_FAIL;
          end
        end
      end
      if (done_load) begin
        out_valid <= 1'b1;
        out_status <= res_status;
        out_start <= res_start;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = OUT_TDATA_W'(out_start);

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("Bitmap word read and written in the same cycle.");

  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_MARK) && we) |-> ((waddr >= s_addr) && (waddr <= e_addr)))
    else $error("Bitmap write outside the run being marked.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == STATUS_FAIL)) |-> (m_axis_tdata == '0))
    else $error("Failed allocation reports a nonzero start.");
`endif

endmodule
